/* rtl/core/calibrated_angle_interpolator_assert.svh */
// Assertion macros shared by the checker of the calibrated angle interpolator.
`ifndef CALIBRATED_ANGLE_INTERPOLATOR_ASSERT_SVH
`define CALIBRATED_ANGLE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calibrated_angle_interpolator: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CAI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calibrated_angle_interpolator: assertion failed");

`endif

/* rtl/core/cai_pkg.sv */
`default_nettype none

package cai_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Field widths.
  localparam int ENTRY_INDEX_W = 5;
  localparam int RAW_W         = 12;
  localparam int INTERVAL_W    = 18;
  localparam int ANGLE_W       = 19;
  localparam int STATUS_W      = 2;

  // Arithmetic widths.
  localparam int DIFF_W    = RAW_W + 1;
  localparam int PROD_W    = INTERVAL_W + 1 + DIFF_W;
  localparam int DIVD_W    = INTERVAL_W + RAW_W;
  localparam int DIV_CNT_W = $clog2(DIVD_W);
  localparam int BASE_W    = INTERVAL_W + IDX_W;
  localparam int SUM_W     = DIVD_W + 2;
  localparam int PLAIN_W   = RAW_W + 6;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = INTERVAL_W'(5120);
  localparam logic [5:0]            COUNTS_TO_ANGLE = 6'd45;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (ANGLE_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2 ** (ANGLE_W - 1)));

  // Operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_INTERP   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_ABOVE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SPAN = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_LOAD     = 2'd3;

  // Microprogram steps.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOAD,
    S_SCAN,
    S_PRIME,
    S_TEST,
    S_ADV,
    S_MISS,
    S_FOUND,
    S_MUL,
    S_DIV,
    S_SUM,
    S_BADSPAN
  } step_e;

  // Datapath actions.
  typedef enum logic [3:0] {
    A_NOP,
    A_LATCH,
    A_LOAD,
    A_RD_FIRST,
    A_CAPTURE,
    A_ADVANCE,
    A_EMIT_MISS,
    A_PREP,
    A_MUL,
    A_DIV,
    A_EMIT_INTERP,
    A_EMIT_BAD
  } act_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_START,
    C_QUERY,
    C_GT,
    C_NOT_LAST,
    C_SPAN_BAD,
    C_DIV_BUSY
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_e target;
  } uword_t;

  typedef struct packed {
    logic is_query;
    logic gt;
    logic not_last;
    logic span_bad;
    logic div_busy;
  } dp_flags_t;

  // The control store. A taken condition jumps to target, otherwise the
  // sequencer falls through to the next step.
  function automatic uword_t ucode_rom(step_e step);
    uword_t w;
    case (step)
      S_IDLE:     w = '{act: A_LATCH,       cond: C_NO_START, target: S_IDLE};
      S_DISPATCH: w = '{act: A_NOP,         cond: C_QUERY,    target: S_SCAN};
      S_LOAD:     w = '{act: A_LOAD,        cond: C_ALWAYS,   target: S_IDLE};
      S_SCAN:     w = '{act: A_RD_FIRST,    cond: C_NEXT,     target: S_IDLE};
      S_PRIME:    w = '{act: A_CAPTURE,     cond: C_ALWAYS,   target: S_ADV};
      S_TEST:     w = '{act: A_CAPTURE,     cond: C_GT,       target: S_FOUND};
      S_ADV:      w = '{act: A_ADVANCE,     cond: C_NOT_LAST, target: S_TEST};
      S_MISS:     w = '{act: A_EMIT_MISS,   cond: C_ALWAYS,   target: S_IDLE};
      S_FOUND:    w = '{act: A_PREP,        cond: C_SPAN_BAD, target: S_BADSPAN};
      S_MUL:      w = '{act: A_MUL,         cond: C_NEXT,     target: S_IDLE};
      S_DIV:      w = '{act: A_DIV,         cond: C_DIV_BUSY, target: S_DIV};
      S_SUM:      w = '{act: A_EMIT_INTERP, cond: C_ALWAYS,   target: S_IDLE};
      S_BADSPAN:  w = '{act: A_EMIT_BAD,    cond: C_ALWAYS,   target: S_IDLE};
      default:    w = '{act: A_NOP,         cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/calibrated_angle_interpolator.sv */
`default_nettype none

// Calibrated angle interpolator. An item is taken when start_i is high and
// busy_o is low; busy_o then stays high until the item is finished. Every item
// gives exactly one result beat: done_o is high for a single cycle with
// angle_o and status_o valid in that cycle, and the receiver cannot stall it,
// so it must capture the beat when it appears. A load (op_i = 0) writes
// raw_count_i into calibration entry entry_index_i (indexes past the table
// are ignored) and reports status 3 with angle 0 after the dispatch and load
// steps. A query (op_i = 1) walks the table from entry 1 upward through the
// single read port of the calibration RAM, then runs a bit-serial divider
// that settles one quotient bit per cycle. A query with no entry above the
// raw count ends after the last entry is tested, and a zero or negative
// span ends right after the scan. The angle is in 1/512-degree units and
// is saturated to the 19-bit signed range.
// sample_interval is written with cfg_we_i/cfg_wdata_i and should only be
// changed while busy_o is low. All table entries read as zero after reset.
//
// Internally a small microprogram in a read-only control store sequences
// the datapath: each step selects one datapath action and an optional
// conditional jump on start_i or a datapath flag (query, entry above raw, last entry,
// bad span, divider still running).

module calibrated_angle_interpolator import cai_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output      logic                      busy_o,
  input  wire logic                      op_i,
  input  wire logic [ENTRY_INDEX_W-1:0]  entry_index_i,
  input  wire logic [RAW_W-1:0]          raw_count_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [INTERVAL_W-1:0]     cfg_wdata_i,
  output      logic                      done_o,
  output      logic signed [ANGLE_W-1:0] angle_o,
  output      logic [STATUS_W-1:0]       status_o
);

  // Action for the current step and the flags that steer the jumps.
  act_e      act;
  dp_flags_t flags;

  cai_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .flags_i (flags),
    .act_o   (act),
    .busy_o  (busy_o)
  );

  // The datapath holds the calibration RAM, the sample_interval register,
  // the scan registers, the divider and the result registers.
  cai_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .act_i         (act),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .raw_count_i   (raw_count_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .flags_o       (flags),
    .done_o        (done_o),
    .angle_o       (angle_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire

/* rtl/core/cai_ram.sv */
`default_nettype none

module cai_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/cai_seq.sv */
`default_nettype none

module cai_seq import cai_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire dp_flags_t flags_i,
  output      act_e      act_o,
  output      logic      busy_o
);

  step_e  upc_q, upc_d;
  uword_t uw;
  logic   take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  always_comb begin
    uw = ucode_rom(upc_q);
    case (uw.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_START: take = !start_i;
      C_QUERY:    take = flags_i.is_query;
      C_GT:       take = flags_i.gt;
      C_NOT_LAST: take = flags_i.not_last;
      C_SPAN_BAD: take = flags_i.span_bad;
      C_DIV_BUSY: take = flags_i.div_busy;
      default:    take = 1'b1;
    endcase
    upc_d = take ? uw.target : step_e'(upc_q + 4'd1);
    // Inputs are only captured on the beat that is actually accepted.
    act_o = (uw.act == A_LATCH && !start_i) ? A_NOP : uw.act;
  end

  assign busy_o = (upc_q != S_IDLE);

endmodule

`default_nettype wire

/* rtl/core/cai_dp.sv */
`default_nettype none

module cai_dp import cai_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire act_e                       act_i,
  input  wire logic                       op_i,
  input  wire logic [ENTRY_INDEX_W-1:0]   entry_index_i,
  input  wire logic [RAW_W-1:0]           raw_count_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [INTERVAL_W-1:0]      cfg_wdata_i,
  output      dp_flags_t                  flags_o,
  output      logic                       done_o,
  output      logic signed [ANGLE_W-1:0]  angle_o,
  output      logic [STATUS_W-1:0]        status_o
);

  // Control state.
  logic [INTERVAL_W-1:0]  interval_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic                   done_q;

  // Working registers.
  logic                     op_q;
  logic [ENTRY_INDEX_W-1:0] idx_q;
  logic [RAW_W-1:0]         raw_q;
  logic                     rvalid_q;
  logic [IDX_W-1:0]         i_q;
  logic [RAW_W-1:0]         hi_q, lo_q, span_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [BASE_W-1:0]        base_q;
  logic                     neg_q;
  logic [RAW_W-1:0]         rem_q;
  logic [DIVD_W-1:0]        quo_q;
  logic [DIV_CNT_W-1:0]     cnt_q;
  logic signed [ANGLE_W-1:0] angle_q;
  logic [STATUS_W-1:0]      status_q;

  logic                     in_range;
  logic                     ram_we;
  logic [IDX_W-1:0]         waddr, raddr;
  logic [RAW_W-1:0]         rdata, entry;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        mag;
  logic [RAW_W:0]           shifted;
  logic [RAW_W+1:0]         trial;
  logic                     qbit;
  logic signed [SUM_W-1:0]  quo_ext, frac, sum;
  logic [PLAIN_W-1:0]       plain;
  logic                     emit;

  assign in_range = (32'(idx_q) < TABLE_DEPTH);
  assign ram_we   = (act_i == A_LOAD) && in_range;
  assign waddr    = IDX_W'(idx_q);

  always_comb begin
    case (act_i)
      A_RD_FIRST: raddr = '0;
      A_ADVANCE:  raddr = flags_o.not_last ? IDX_W'(i_q + 1'b1) : i_q;
      default:    raddr = i_q;
    endcase
  end

  cai_ram #(
    .WIDTH (RAW_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (raw_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Entries never loaded since reset read as zero.
  assign entry = rvalid_q ? rdata : '0;

  assign flags_o.is_query = (op_q == OP_QUERY);
  assign flags_o.gt       = (entry > raw_q);
  assign flags_o.not_last = (i_q != IDX_W'(TABLE_DEPTH - 1));
  assign flags_o.span_bad = (hi_q <= lo_q);
  assign flags_o.div_busy = (cnt_q != DIV_CNT_W'(DIVD_W - 1));

  always_comb begin
    prod    = PROD_W'($signed({1'b0, interval_q})) * PROD_W'(diff_q);
    mag     = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    shifted = {rem_q, quo_q[DIVD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, span_q};
    qbit    = !trial[RAW_W+1];
    quo_ext = $signed({{(SUM_W - DIVD_W){1'b0}}, quo_q});
    frac    = neg_q ? -quo_ext : quo_ext;
    sum     = $signed({{(SUM_W - BASE_W){1'b0}}, base_q}) + frac;
    plain   = PLAIN_W'(raw_q) * PLAIN_W'(COUNTS_TO_ANGLE);
    emit    = (act_i == A_LOAD) || (act_i == A_EMIT_MISS) ||
              (act_i == A_EMIT_INTERP) || (act_i == A_EMIT_BAD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RESET;
      valid_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        valid_q[waddr] <= 1'b1;
      end
      done_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    rvalid_q <= valid_q[raddr];
    case (act_i)
      A_LATCH: begin
        op_q  <= op_i;
        idx_q <= entry_index_i;
        raw_q <= raw_count_i;
      end
      A_LOAD: begin
        angle_q  <= '0;
        status_q <= STATUS_LOAD;
      end
      A_RD_FIRST: begin
        i_q <= '0;
      end
      A_CAPTURE: begin
        hi_q <= entry;
      end
      A_ADVANCE: begin
        lo_q <= hi_q;
        i_q  <= IDX_W'(i_q + 1'b1);
      end
      A_EMIT_MISS: begin
        angle_q  <= ANGLE_W'(plain);
        status_q <= STATUS_NO_ABOVE;
      end
      A_PREP: begin
        diff_q <= $signed({1'b0, raw_q}) - $signed({1'b0, lo_q});
        base_q <= BASE_W'(interval_q) * BASE_W'(IDX_W'(i_q - 1'b1));
        span_q <= hi_q - lo_q;
      end
      A_MUL: begin
        neg_q <= prod[PROD_W-1];
        quo_q <= mag[DIVD_W-1:0];
        rem_q <= '0;
        cnt_q <= '0;
      end
      A_DIV: begin
        rem_q <= qbit ? trial[RAW_W-1:0] : shifted[RAW_W-1:0];
        quo_q <= {quo_q[DIVD_W-2:0], qbit};
        cnt_q <= DIV_CNT_W'(cnt_q + 1'b1);
      end
      A_EMIT_INTERP: begin
        if (sum > SAT_HI) begin
          angle_q <= ANGLE_W'(SAT_HI);
        end else if (sum < SAT_LO) begin
          angle_q <= ANGLE_W'(SAT_LO);
        end else begin
          angle_q <= sum[ANGLE_W-1:0];
        end
        status_q <= STATUS_INTERP;
      end
      A_EMIT_BAD: begin
        angle_q  <= ANGLE_W'(plain);
        status_q <= STATUS_BAD_SPAN;
      end
      default: begin
      end
    endcase
  end

  assign done_o   = done_q;
  assign angle_o  = angle_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

/* rtl/core/cai_chk.sv */
`default_nettype none

`include "calibrated_angle_interpolator_assert.svh"

module cai_chk import cai_pkg::*; (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      start_i,
  input wire logic                      busy_o,
  input wire logic                      op_i,
  input wire logic                      done_o,
  input wire logic signed [ANGLE_W-1:0] angle_o,
  input wire logic [STATUS_W-1:0]       status_o
);

  logic load_taken;
  logic load_beat;

  assign load_taken = start_i && !busy_o && (op_i == OP_LOAD);
  assign load_beat  = done_o && (status_o == STATUS_LOAD) && (angle_o == '0);

  // A taken item keeps the block busy on the following cycle.
  `CAI_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)

  // The block finishes an item in the same cycle that its result appears.
  `CAI_ASSERT_IMPLIES(a_fell_done, clk_i, rst_ni, $fell(busy_o), done_o)

  // Result strobes never come back to back.
  `CAI_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

  // A load reports completion with a zero angle once its dispatch and load steps are done.
  `CAI_ASSERT_IMPLIES(a_load_result, clk_i, rst_ni, load_taken, ##3 load_beat)

endmodule

bind calibrated_angle_interpolator cai_chk u_chk (.*);

`default_nettype wire
